/* src/utf8v_pkg.sv */
`default_nettype none

package utf8v_pkg;

   localparam int unsigned ByteWidth = 8;
   localparam int unsigned CodeWidth = 21;

   typedef logic [ByteWidth-1:0] byte_type;
   typedef logic [CodeWidth-1:0] code_type;
   typedef logic [2:0]           seq_len_type;
   typedef logic [1:0]           remain_type;

   localparam code_type CpMax       = 21'h10FFFF;
   localparam code_type SurrogateLo = 21'h00D800;
   localparam code_type SurrogateHi = 21'h00DFFF;
   localparam code_type NoncharLo   = 21'h00FDD0;
   localparam code_type NoncharHi   = 21'h00FDEF;
   localparam code_type CpTab       = 21'h000009;
   localparam code_type CpDel       = 21'h00007F;
   localparam code_type MinLen1     = 21'h000020;
   localparam code_type MinLen2     = 21'h000080;
   localparam code_type MinLen3     = 21'h000800;
   localparam code_type MinLen4     = 21'h010000;

   localparam byte_type ContMask    = 8'hC0;
   localparam byte_type ContTag     = 8'h80;
   localparam byte_type ContPayload = 8'h3F;

   function automatic seq_len_type lead_len(input byte_type b);
      seq_len_type len;
      if (b < 8'h80) begin
         len = 3'd1;
      end else if (b < 8'hC0) begin
         len = 3'd0;
      end else if (b < 8'hE0) begin
         len = 3'd2;
      end else if (b < 8'hF0) begin
         len = 3'd3;
      end else if (b < 8'hF8) begin
         len = 3'd4;
      end else begin
         len = 3'd0;
      end
      return len;
   endfunction

   function automatic code_type lead_bits(input byte_type b, input seq_len_type len);
      byte_type mask;
      unique case (len)
         3'd2:    mask = 8'h1F;
         3'd3:    mask = 8'h0F;
         3'd4:    mask = 8'h07;
         default: mask = 8'hFF;
      endcase
      return {{(CodeWidth-ByteWidth){1'b0}}, b & mask};
   endfunction

   function automatic logic cp_ok(input code_type cp, input seq_len_type len);
      logic ok;
      logic below;
      ok    = 1'b1;
      below = 1'b0;
      unique case (len)
         3'd0:    below = 1'b1;
         3'd1:    below = (cp < MinLen1);
         3'd2:    below = (cp < MinLen2);
         3'd3:    below = (cp < MinLen3);
         3'd4:    below = (cp < MinLen4);
         default: ok = 1'b0;
      endcase
      if (below && (cp != CpTab)) ok = 1'b0;
      if (cp == CpDel) ok = 1'b0;
      if (cp > CpMax) ok = 1'b0;
      if ((cp >= SurrogateLo) && (cp <= SurrogateHi)) ok = 1'b0;
      if ((cp >= NoncharLo) && (cp <= NoncharHi)) ok = 1'b0;
      if (cp[15:1] == 15'h7FFF) ok = 1'b0;
      return ok;
   endfunction

endpackage

`default_nettype wire

/* src/utf8_stream_validator_top.sv */
// The verdict is registered and appears on rsp_ in the cycle after the last byte's transaction.
// Throughput: one byte per cycle while req_stall is low; the decode state register updates once per byte.
// A last byte stalls only while an earlier verdict is still held on the response side.
// Reset (synchronous, active high) clears the decode state and the response valid.
`default_nettype none

module utf8_stream_validator_top
   import utf8v_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_last_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_is_valid
);

   logic        error_ff, error_in;
   remain_type  remain_ff, remain_in;
   seq_len_type len_ff, len_in;
   code_type    acc_ff, acc_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_is_valid_ff, rsp_is_valid_in;

   logic        req_take;
   seq_len_type lead_class;
   code_type    acc_shift;
   remain_type  remain_dec;
   logic        err_step;
   remain_type  remain_step;
   seq_len_type len_step;
   code_type    acc_step;

   assign req_stall = rsp_valid_ff && rsp_stall && req_last_byte;
   assign req_take  = req_valid && !req_stall;

   assign lead_class = lead_len(req_data_byte);
   assign acc_shift  = {acc_ff[CodeWidth-7:0], req_data_byte[5:0] & ContPayload[5:0]};
   assign remain_dec = remain_ff - 2'd1;

   always_comb begin
      err_step    = error_ff;
      remain_step = remain_ff;
      len_step    = len_ff;
      acc_step    = acc_ff;
      if (!error_ff) begin
         if (remain_ff == 2'd0) begin
            if (lead_class == 3'd0) begin
               err_step = 1'b1;
            end else if (lead_class == 3'd1) begin
               if (!cp_ok({{(CodeWidth-ByteWidth){1'b0}}, req_data_byte}, 3'd1)) begin
                  err_step = 1'b1;
               end
            end else begin
               acc_step    = lead_bits(req_data_byte, lead_class);
               len_step    = lead_class;
               remain_step = 2'(lead_class - 3'd1);
               if (req_last_byte) err_step = 1'b1;
            end
         end else begin
            if ((req_data_byte & ContMask) != ContTag) begin
               err_step = 1'b1;
            end else begin
               acc_step    = acc_shift;
               remain_step = remain_dec;
               if (remain_dec == 2'd0) begin
                  if (!cp_ok(acc_shift, len_ff)) err_step = 1'b1;
                  len_step = '0;
                  acc_step = '0;
               end else if (req_last_byte) begin
                  err_step = 1'b1;
               end
            end
         end
         if (err_step) begin
            remain_step = '0;
            len_step    = '0;
            acc_step    = '0;
         end
      end
   end

   always_comb begin
      error_in        = error_ff;
      remain_in       = remain_ff;
      len_in          = len_ff;
      acc_in          = acc_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_is_valid_in = rsp_is_valid_ff;
      if (req_take) begin
         if (req_last_byte) begin
            error_in        = 1'b0;
            remain_in       = '0;
            len_in          = '0;
            acc_in          = '0;
            rsp_valid_in    = 1'b1;
            rsp_is_valid_in = !err_step;
         end else begin
            error_in  = err_step;
            remain_in = remain_step;
            len_in    = len_step;
            acc_in    = acc_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         error_ff     <= 1'b0;
         remain_ff    <= '0;
         len_ff       <= '0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         error_ff     <= error_in;
         remain_ff    <= remain_in;
         len_ff       <= len_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_is_valid_ff <= rsp_is_valid_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_is_valid = rsp_is_valid_ff;

`ifndef SYNTHESIS
   a_len_tracks_remain: assert property (@(posedge clock) disable iff (reset)
      (remain_ff != 2'd0) |-> ((len_ff >= 3'd2) && ({1'b0, remain_ff} < len_ff)))
      else $error("sequence length inconsistent with pending continuation count");

   a_idle_len_clear: assert property (@(posedge clock) disable iff (reset)
      (remain_ff == 2'd0) |-> (len_ff == 3'd0))
      else $error("sequence length left set with no continuation pending");

   a_error_clears_decode: assert property (@(posedge clock) disable iff (reset)
      error_ff |-> ((remain_ff == 2'd0) && (acc_ff == '0)))
      else $error("decode state not cleared after fault");

   a_last_emits: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_last_byte) |=> (rsp_valid_ff && !error_ff && (remain_ff == 2'd0)))
      else $error("last byte did not produce a verdict and clear state");
`endif

endmodule

`default_nettype wire
